FILE: design/dpw_pkg.sv
`timescale 1ns / 1ps

package dpw_pkg;

  // Port field widths
  localparam int COORD_W    = 12;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int QUAT_W     = 16;
  localparam int TRANS_W    = 32;
  localparam int WORLD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Back-projection datapath widths
  localparam int SPAN_W  = COORD_W + 2;            // 2u - 651, signed
  localparam int SPROD_W = SPAN_W + DEPTH_W + 1;   // span times depth, signed
  localparam int MAG_W   = 29;                     // |span * depth| < 2^29
  localparam int RECIP_W = 32;                     // reciprocal constant
  localparam int MPROD_W = MAG_W + RECIP_W;
  localparam int EST_W   = 25;                     // camera coordinate magnitude
  localparam int REM_W   = 18;                     // remainder below 3 * divisor
  localparam int CAM_W   = EST_W + 1;              // signed camera coordinate Q16.16

  // Twice the principal point (cx 325.5, cy 253.5)
  localparam int CX2 = 651;
  localparam int CY2 = 507;

  // Per-lane rounded division q = floor((mag * 2^SH + H) / D), with D odd.
  //   x: 65536 / 1036000 = 2048 / 32375
  //   y: 65536 / 1038000 = 4096 / 64875
  //   z: 65536 / 1000    = 8192 / 125
  localparam int NLANE = 3;
  localparam int unsigned DIV_D  [NLANE] = '{32375, 64875, 125};
  localparam int unsigned DIV_H  [NLANE] = '{16187, 32437, 62};
  localparam int unsigned DIV_SH [NLANE] = '{11, 12, 13};
  localparam int unsigned DIV_K  [NLANE] = '{35, 35, 25};
  localparam longint unsigned DIV_M [NLANE] = '{
    (64'd1 << 46) / 64'd32375,
    (64'd1 << 47) / 64'd64875,
    (64'd1 << 38) / 64'd125
  };

  // Rotation datapath widths
  localparam int PP_W     = 2 * QUAT_W;            // quaternion component products
  localparam int ROT_W    = 34;                    // matrix entry, signed Q6.28
  localparam int ROT_ONE  = 1 << 28;
  localparam int PROD_W   = ROT_W + CAM_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int FRAC_SH  = 28;
  localparam int RND_HALF = 1 << (FRAC_SH - 1);
  localparam int QR_W     = ACC_W - FRAC_SH;
  localparam int SUM_W    = QR_W + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W  = 3'd0,
    REG_QUAT_X  = 3'd1,
    REG_QUAT_Y  = 3'd2,
    REG_QUAT_Z  = 3'd3,
    REG_TRANS_X = 3'd4,
    REG_TRANS_Y = 3'd5,
    REG_TRANS_Z = 3'd6
  } cfg_reg_t;

  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 16'd16384;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [DEPTH_W-1:0] depth;
    color_t             color;
  } pix_word_t;

  typedef logic [NLANE-1:0][CAM_W-1:0] cam_vec_t;

  typedef struct packed {
    cam_vec_t cam;
    color_t   color;
  } cam_word_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  typedef logic [NLANE-1:0][NLANE-1:0][ROT_W-1:0] rmat_t;

endpackage

FILE: design/dpw_in_if.sv
`timescale 1ns / 1ps

interface dpw_in_if import dpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [DEPTH_W-1:0] depth_raw;
  logic [COLOR_W-1:0] blue_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] red_in;

  modport source (
    output valid, col, row, depth_raw, blue_in, green_in, red_in,
    input  ready
  );

  modport sink (
    input  valid, col, row, depth_raw, blue_in, green_in, red_in,
    output ready
  );
endinterface

FILE: design/dpw_out_if.sv
`timescale 1ns / 1ps

interface dpw_out_if import dpw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;
  logic [COLOR_W-1:0]        blue_out;
  logic [COLOR_W-1:0]        green_out;
  logic [COLOR_W-1:0]        red_out;

  modport source (
    output valid, world_x, world_y, world_z, blue_out, green_out, red_out,
    input  ready
  );

  modport sink (
    input  valid, world_x, world_y, world_z, blue_out, green_out, red_out,
    output ready
  );
endinterface

FILE: design/dpw_rotmat.sv
`timescale 1ns / 1ps

// Rotation matrix of an unnormalized quaternion, Q6.28 entries, two register stages.
module dpw_rotmat import dpw_pkg::*; (
  input  logic  clk,
  input  quat_t quat,
  output rmat_t rmat
);

  logic signed [PP_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  rmat_t                  rmat_r;
  rmat_t                  rmat_nxt;

  // Form the component products
  always_ff @(posedge clk) begin
    xx_r <= quat.x * quat.x;
    yy_r <= quat.y * quat.y;
    zz_r <= quat.z * quat.z;
    xy_r <= quat.x * quat.y;
    xz_r <= quat.x * quat.z;
    yz_r <= quat.y * quat.z;
    wx_r <= quat.w * quat.x;
    wy_r <= quat.w * quat.y;
    wz_r <= quat.w * quat.z;
  end

  // Combine products into entries: diagonal is one minus twice a sum of squares
  always_comb begin
    rmat_nxt[0][0] = ROT_W'(ROT_ONE) - ((ROT_W'(yy_r) + ROT_W'(zz_r)) << 1);
    rmat_nxt[0][1] = (ROT_W'(xy_r) - ROT_W'(wz_r)) << 1;
    rmat_nxt[0][2] = (ROT_W'(xz_r) + ROT_W'(wy_r)) << 1;
    rmat_nxt[1][0] = (ROT_W'(xy_r) + ROT_W'(wz_r)) << 1;
    rmat_nxt[1][1] = ROT_W'(ROT_ONE) - ((ROT_W'(xx_r) + ROT_W'(zz_r)) << 1);
    rmat_nxt[1][2] = (ROT_W'(yz_r) - ROT_W'(wx_r)) << 1;
    rmat_nxt[2][0] = (ROT_W'(xz_r) - ROT_W'(wy_r)) << 1;
    rmat_nxt[2][1] = (ROT_W'(yz_r) + ROT_W'(wx_r)) << 1;
    rmat_nxt[2][2] = ROT_W'(ROT_ONE) - ((ROT_W'(xx_r) + ROT_W'(yy_r)) << 1);
  end

  always_ff @(posedge clk) begin
    rmat_r <= rmat_nxt;
  end

  assign rmat = rmat_r;

endmodule

FILE: design/dpw_backproj.sv
`timescale 1ns / 1ps

// Pinhole back-projection of one pixel word to a camera point, five stages.
// Each coordinate is a rounded division by a constant: reciprocal estimate,
// then a remainder check that adds zero, one or two.
module dpw_backproj import dpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_vld,
  output logic      up_rdy,
  input  pix_word_t up_word,
  output logic      dn_vld,
  input  logic      dn_rdy,
  output cam_word_t dn_word
);

  // Stage enables: a stage loads when empty or when its successor loads
  logic en_a, en_b, en_c, en_d, en_e;

  // Stage A: registered pixel
  logic      a_vld_r;
  pix_word_t a_word_r;

  // Stage B: sign and magnitude of the scaled offset
  logic                   b_vld_r;
  logic [NLANE-1:0]       b_sgn_r, b_sgn_nxt;
  logic [MAG_W-1:0]       b_mag_r [NLANE];
  logic [MAG_W-1:0]       b_mag_nxt [NLANE];
  color_t                 b_color_r;
  logic signed [SPAN_W-1:0]  span [2];
  logic signed [SPROD_W-1:0] sprod [2];

  // Stage C: reciprocal estimate
  logic                   c_vld_r;
  logic [NLANE-1:0]       c_sgn_r;
  logic [MAG_W-1:0]       c_mag_r [NLANE];
  logic [EST_W-1:0]       c_est_r [NLANE];
  logic [EST_W-1:0]       c_est_nxt [NLANE];
  logic [MPROD_W-1:0]     mprod [NLANE];
  color_t                 c_color_r;

  // Stage D: remainder of the estimate
  logic                   d_vld_r;
  logic [NLANE-1:0]       d_sgn_r;
  logic [EST_W-1:0]       d_est_r [NLANE];
  logic [REM_W-1:0]       d_rem_r [NLANE];
  logic [REM_W-1:0]       d_rem_nxt [NLANE];
  color_t                 d_color_r;

  // Stage E: corrected, signed camera coordinate
  logic                   e_vld_r;
  cam_vec_t               e_cam_r, e_cam_nxt;
  color_t                 e_color_r;
  logic [EST_W-1:0]       quo [NLANE];

  assign en_e   = !e_vld_r || dn_rdy;
  assign en_d   = !d_vld_r || en_e;
  assign en_c   = !c_vld_r || en_d;
  assign en_b   = !b_vld_r || en_c;
  assign en_a   = !a_vld_r || en_b;
  assign up_rdy = en_a;

  // Advance valid bits; drop a word with zero depth at entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      if (en_a) a_vld_r <= up_vld && (up_word.depth != '0);
      if (en_b) b_vld_r <= a_vld_r;
      if (en_c) c_vld_r <= b_vld_r;
      if (en_d) d_vld_r <= c_vld_r;
      if (en_e) e_vld_r <= d_vld_r;
    end
  end

  // Offset from the principal point times depth
  always_comb begin
    span[0]  = $signed({1'b0, a_word_r.col, 1'b0}) - SPAN_W'(CX2);
    span[1]  = $signed({1'b0, a_word_r.row, 1'b0}) - SPAN_W'(CY2);
    for (int i = 0; i < 2; i++) begin
      sprod[i]     = span[i] * $signed({1'b0, a_word_r.depth});
      b_sgn_nxt[i] = sprod[i][SPROD_W-1];
      b_mag_nxt[i] = MAG_W'(sprod[i][SPROD_W-1] ? -sprod[i] : sprod[i]);
    end
    b_sgn_nxt[2] = 1'b0;
    b_mag_nxt[2] = MAG_W'(a_word_r.depth);
  end

  // Quotient estimate from the reciprocal, low by at most two
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mprod[i]     = MPROD_W'(b_mag_r[i]) * MPROD_W'(DIV_M[i]);
      c_est_nxt[i] = EST_W'(mprod[i] >> DIV_K[i]);
    end
  end

  // Remainder, exact modulo 2^REM_W
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      d_rem_nxt[i] = (REM_W'(c_mag_r[i]) << DIV_SH[i]) + REM_W'(DIV_H[i])
                     - REM_W'(c_est_r[i] * DIV_D[i]);
    end
  end

  // Correct the estimate and restore the sign
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (d_rem_r[i] >= REM_W'(2 * DIV_D[i])) begin
        quo[i] = d_est_r[i] + EST_W'(2);
      end else if (d_rem_r[i] >= REM_W'(DIV_D[i])) begin
        quo[i] = d_est_r[i] + EST_W'(1);
      end else begin
        quo[i] = d_est_r[i];
      end
      e_cam_nxt[i] = d_sgn_r[i] ? -CAM_W'(quo[i]) : CAM_W'(quo[i]);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en_a) a_word_r <= up_word;
    if (en_b) begin
      b_sgn_r   <= b_sgn_nxt;
      b_mag_r   <= b_mag_nxt;
      b_color_r <= a_word_r.color;
    end
    if (en_c) begin
      c_sgn_r   <= b_sgn_r;
      c_mag_r   <= b_mag_r;
      c_est_r   <= c_est_nxt;
      c_color_r <= b_color_r;
    end
    if (en_d) begin
      d_sgn_r   <= c_sgn_r;
      d_est_r   <= c_est_r;
      d_rem_r   <= d_rem_nxt;
      d_color_r <= c_color_r;
    end
    if (en_e) begin
      e_cam_r   <= e_cam_nxt;
      e_color_r <= d_color_r;
    end
  end

  assign dn_vld        = e_vld_r;
  assign dn_word.cam   = e_cam_r;
  assign dn_word.color = e_color_r;

endmodule

FILE: design/depth_pixel_to_world_point.sv
`timescale 1ns / 1ps

// Depth pixel to world point. Each pixel word (column, row, depth in mm, color)
// is back-projected through fixed pinhole intrinsics, rotated by the matrix of
// the pose quaternion (used as written, not normalized), translated, and sent
// out as saturated signed Q16.16 meters with its color bytes. A pixel with zero
// depth is taken and produces no output word. The datapath is a nine-stage
// pipeline: while the output is not stalled, one pixel per clock is accepted
// and one point per clock delivered. Five stages do the constant divisions of
// the back-projection, then one multiply stage, one sum stage, one rounding
// stage and the output register. Backpressure stalls only the stages behind a
// full one, so bubbles are absorbed. A pose write reaches the rotation matrix
// through the product and matrix registers of dpw_rotmat.
module depth_pixel_to_world_point import dpw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dpw_in_if.sink                in_pix,
  dpw_out_if.source             out_pt,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Pose registers
  quat_t                     quat_r;
  logic signed [TRANS_W-1:0] trans_r [NLANE];

  rmat_t     rmat;
  pix_word_t pix_word;
  logic      bp_dn_vld, bp_dn_rdy;
  cam_word_t bp_dn_word;

  logic en_f, en_g, en_h, en_i;

  // Stage F: matrix entry times camera coordinate
  logic                      f_vld_r;
  logic signed [PROD_W-1:0]  f_prod_r [NLANE][NLANE];
  logic signed [PROD_W-1:0]  f_prod_nxt [NLANE][NLANE];
  color_t                    f_color_r;

  // Stage G: row sums
  logic                      g_vld_r;
  logic signed [ACC_W-1:0]   g_acc_r [NLANE];
  logic signed [ACC_W-1:0]   g_acc_nxt [NLANE];
  color_t                    g_color_r;

  // Stage H: round to Q16.16, ties away from zero
  logic                      h_vld_r;
  logic signed [QR_W-1:0]    h_q_r [NLANE];
  logic signed [QR_W-1:0]    h_q_nxt [NLANE];
  color_t                    h_color_r;

  // Stage I: translate and saturate
  logic                      o_vld_r;
  logic signed [WORLD_W-1:0] o_world_r [NLANE];
  logic signed [WORLD_W-1:0] o_world_nxt [NLANE];
  logic signed [SUM_W-1:0]   wsum [NLANE];
  color_t                    o_color_r;

  // Write pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w   <= QUAT_W_RESET;
      quat_r.x   <= '0;
      quat_r.y   <= '0;
      quat_r.z   <= '0;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUAT_W:  quat_r.w   <= cfg_wdata[QUAT_W-1:0];
        REG_QUAT_X:  quat_r.x   <= cfg_wdata[QUAT_W-1:0];
        REG_QUAT_Y:  quat_r.y   <= cfg_wdata[QUAT_W-1:0];
        REG_QUAT_Z:  quat_r.z   <= cfg_wdata[QUAT_W-1:0];
        REG_TRANS_X: trans_r[0] <= cfg_wdata[TRANS_W-1:0];
        REG_TRANS_Y: trans_r[1] <= cfg_wdata[TRANS_W-1:0];
        REG_TRANS_Z: trans_r[2] <= cfg_wdata[TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  dpw_rotmat u_rotmat (
    .clk  (clk),
    .quat (quat_r),
    .rmat (rmat)
  );

  assign pix_word.col         = in_pix.col;
  assign pix_word.row         = in_pix.row;
  assign pix_word.depth       = in_pix.depth_raw;
  assign pix_word.color.blue  = in_pix.blue_in;
  assign pix_word.color.green = in_pix.green_in;
  assign pix_word.color.red   = in_pix.red_in;

  dpw_backproj u_backproj (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_pix.valid),
    .up_rdy  (in_pix.ready),
    .up_word (pix_word),
    .dn_vld  (bp_dn_vld),
    .dn_rdy  (bp_dn_rdy),
    .dn_word (bp_dn_word)
  );

  assign en_i      = !o_vld_r || out_pt.ready;
  assign en_h      = !h_vld_r || en_i;
  assign en_g      = !g_vld_r || en_h;
  assign en_f      = !f_vld_r || en_g;
  assign bp_dn_rdy = en_f;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (en_f) f_vld_r <= bp_dn_vld;
      if (en_g) g_vld_r <= f_vld_r;
      if (en_h) h_vld_r <= g_vld_r;
      if (en_i) o_vld_r <= h_vld_r;
    end
  end

  // Rotate: nine products, three row sums
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      for (int j = 0; j < NLANE; j++) begin
        f_prod_nxt[i][j] = $signed(rmat[i][j]) * $signed(bp_dn_word.cam[j]);
      end
      g_acc_nxt[i] = ACC_W'(f_prod_r[i][0]) + ACC_W'(f_prod_r[i][1])
                     + ACC_W'(f_prod_r[i][2]);
    end
  end

  // Round, translate and clamp to the signed 32-bit range
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      h_q_nxt[i] = QR_W'((g_acc_r[i] + (g_acc_r[i][ACC_W-1] ? ACC_W'(RND_HALF - 1)
                                                             : ACC_W'(RND_HALF)))
                         >>> FRAC_SH);
      wsum[i] = SUM_W'(h_q_r[i]) + SUM_W'(trans_r[i]);
      if (wsum[i][SUM_W-1:WORLD_W-1] == '0 || wsum[i][SUM_W-1:WORLD_W-1] == '1) begin
        o_world_nxt[i] = wsum[i][WORLD_W-1:0];
      end else if (wsum[i][SUM_W-1]) begin
        o_world_nxt[i] = {1'b1, {(WORLD_W-1){1'b0}}};
      end else begin
        o_world_nxt[i] = {1'b0, {(WORLD_W-1){1'b1}}};
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en_f) begin
      f_prod_r  <= f_prod_nxt;
      f_color_r <= bp_dn_word.color;
    end
    if (en_g) begin
      g_acc_r   <= g_acc_nxt;
      g_color_r <= f_color_r;
    end
    if (en_h) begin
      h_q_r     <= h_q_nxt;
      h_color_r <= g_color_r;
    end
    if (en_i) begin
      o_world_r <= o_world_nxt;
      o_color_r <= h_color_r;
    end
  end

  assign out_pt.valid     = o_vld_r;
  assign out_pt.world_x   = o_world_r[0];
  assign out_pt.world_y   = o_world_r[1];
  assign out_pt.world_z   = o_world_r[2];
  assign out_pt.blue_out  = o_color_r.blue;
  assign out_pt.green_out = o_color_r.green;
  assign out_pt.red_out   = o_color_r.red;

  // A back-projected word always has positive depth; zero depth never gets in
  a_cam_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
    bp_dn_vld |-> $signed(bp_dn_word.cam[2]) > 0)
    else $error("camera z not positive on a valid word");

  // A stalled sum stage keeps its word
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    g_vld_r && !en_h |=> g_vld_r && $stable(g_acc_r[0]))
    else $error("sum stage lost its word during a stall");

  // A rounded word moves into the output register when it advances
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r && en_i |=> o_vld_r)
    else $error("output register missed a word");

endmodule
